>>> design/tlpw_pkg.sv
`timescale 1ns / 1ps
package tlpw_pkg;

  localparam int unsigned Processes   = 4;
  localparam int unsigned RamFrames   = 64;
  localparam int unsigned DiskSlots   = 1024;
  localparam int unsigned TablePool   = 64;
  localparam int unsigned DirSize     = 4096;
  localparam int unsigned TblSize     = 256;

  localparam int unsigned PidW   = 2;
  localparam int unsigned DirW   = 12;
  localparam int unsigned TblW   = 8;
  localparam int unsigned OffW   = 12;
  localparam int unsigned FrameW = 6;
  localparam int unsigned SlotW  = 10;
  localparam int unsigned PoolW  = 6;
  localparam int unsigned StampW = 32;
  localparam int unsigned StatW  = 3;
  localparam int unsigned PaW    = 18;

  localparam int unsigned DirAddrW = PidW + DirW;
  localparam int unsigned PteAddrW = PoolW + TblW;
  localparam int unsigned DirEntW  = 1 + PoolW;
  localparam int unsigned PteEntW  = 2 + SlotW;
  localparam int unsigned OwnW     = PidW + DirW + TblW;
  localparam int unsigned CntW     = DirAddrW + 1;

  localparam logic [StatW-1:0] StHit     = 3'd0;
  localparam logic [StatW-1:0] StMapped  = 3'd1;
  localparam logic [StatW-1:0] StSwapped = 3'd2;
  localparam logic [StatW-1:0] StNoDisk  = 3'd3;
  localparam logic [StatW-1:0] StNoTable = 3'd4;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIR_RD,
    S_TBL_CLR,
    S_PTE_RD,
    S_FREE_SCAN,
    S_OLD_SCAN,
    S_DISK_SCAN,
    S_OWN_RD,
    S_OWNDIR_RD,
    S_MAP,
    S_FINISH
  } state_e;

endpackage

>>> design/two_level_page_walk_lru_swap.sv
`timescale 1ns / 1ps
// Access hit: reads the directory, then the page table, then registers the
// result. A new table is cleared entry by entry first. A miss scans the free
// map for a frame; full RAM adds an oldest-stamp scan, a disk-slot scan and
// an owner update. One access at a time, set by the shared scan counter and
// simple dual-port RAMs. After reset an async-cleared controller sweeps the
// directory (disk free map over its first 1024 entries) before the first
// transfer is taken.
module two_level_page_walk_lru_swap (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             func_i,
  input  logic [tlpw_pkg::PidW-1:0]        process_id_i,
  input  logic [31:0]                      virtual_address_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [tlpw_pkg::StatW-1:0]       status_o,
  output logic [tlpw_pkg::PaW-1:0]         physical_address_o,
  output logic                             evicted_o,
  output logic [tlpw_pkg::FrameW-1:0]      evicted_ram_frame_o,
  output logic [tlpw_pkg::SlotW-1:0]       evicted_disk_slot_o,
  output logic [tlpw_pkg::SlotW-1:0]       swapped_in_slot_o
);
  import tlpw_pkg::*;

  state_e state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [PidW-1:0]    pid_q, pid_d;
  logic [DirW-1:0]    dir_q, dir_d;
  logic [TblW-1:0]    tbl_q, tbl_d;
  logic [OffW-1:0]    off_q, off_d;
  logic [PoolW-1:0]   pool_q, pool_d;
  logic [PteEntW-1:0] e_q, e_d;
  logic [FrameW-1:0]  frame_q, frame_d;
  logic [FrameW-1:0]  victim_q, victim_d;
  logic [StampW-1:0]  oldest_q, oldest_d;
  logic [SlotW-1:0]   slot_q, slot_d;
  logic [TblW-1:0]    own_t_q, own_t_d;
  logic               ev_q, ev_d;
  logic [StatW-1:0]   st_q, st_d;
  logic [PoolW:0]     pool_used_q, pool_used_d;
  logic [RamFrames-1:0] free_q, free_d;
  logic [StampW-1:0]  tick_q, tick_d;
  logic               out_valid_q, out_valid_d;
  logic [StatW-1:0]   out_st_q, out_st_d;
  logic [PaW-1:0]     out_pa_q, out_pa_d;
  logic               out_ev_q, out_ev_d;
  logic [FrameW-1:0]  out_evf_q, out_evf_d;
  logic [SlotW-1:0]   out_evs_q, out_evs_d;
  logic [SlotW-1:0]   out_insl_q, out_insl_d;

  logic                dir_we;
  logic [DirAddrW-1:0] dir_waddr, dir_raddr;
  logic [DirEntW-1:0]  dir_wdata, dir_rdata;
  logic                pte_we;
  logic [PteAddrW-1:0] pte_waddr, pte_raddr;
  logic [PteEntW-1:0]  pte_wdata, pte_rdata;
  logic                stamp_we;
  logic [FrameW-1:0]   stamp_waddr, stamp_raddr;
  logic [StampW-1:0]   stamp_rdata;
  logic                own_we;
  logic [FrameW-1:0]   own_raddr;
  logic [OwnW-1:0]     own_wdata, own_rdata;
  logic                disk_we;
  logic [SlotW-1:0]    disk_waddr, disk_raddr;
  logic                disk_wdata;
  logic [0:0]          disk_rdata;
  logic [FrameW-1:0]   prev_idx;
  logic [SlotW-1:0]    prev_slot;

  tlpw_ram #(.Width(DirEntW), .Depth(Processes * DirSize)) u_dir (
    .clk_i, .we_i(dir_we), .waddr_i(dir_waddr), .wdata_i(dir_wdata),
    .raddr_i(dir_raddr), .rdata_o(dir_rdata));
  tlpw_ram #(.Width(PteEntW), .Depth(TablePool * TblSize)) u_pte (
    .clk_i, .we_i(pte_we), .waddr_i(pte_waddr), .wdata_i(pte_wdata),
    .raddr_i(pte_raddr), .rdata_o(pte_rdata));
  tlpw_ram #(.Width(StampW), .Depth(RamFrames)) u_stamp (
    .clk_i, .we_i(stamp_we), .waddr_i(stamp_waddr), .wdata_i(tick_q),
    .raddr_i(stamp_raddr), .rdata_o(stamp_rdata));
  tlpw_ram #(.Width(OwnW), .Depth(RamFrames)) u_own (
    .clk_i, .we_i(own_we), .waddr_i(frame_q), .wdata_i(own_wdata),
    .raddr_i(own_raddr), .rdata_o(own_rdata));
  tlpw_ram #(.Width(1), .Depth(DiskSlots)) u_disk (
    .clk_i, .we_i(disk_we), .waddr_i(disk_waddr), .wdata_i(disk_wdata),
    .raddr_i(disk_raddr), .rdata_o(disk_rdata));

  assign in_stall_o          = (state_q != S_IDLE);
  assign out_valid_o         = out_valid_q;
  assign status_o            = out_st_q;
  assign physical_address_o  = out_pa_q;
  assign evicted_o           = out_ev_q;
  assign evicted_ram_frame_o = out_evf_q;
  assign evicted_disk_slot_o = out_evs_q;
  assign swapped_in_slot_o   = out_insl_q;

  assign prev_idx  = FrameW'(cnt_q - 1'b1);
  assign prev_slot = SlotW'(cnt_q - 1'b1);
  assign own_wdata = {pid_q, dir_q, tbl_q};

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pid_d       = pid_q;
    dir_d       = dir_q;
    tbl_d       = tbl_q;
    off_d       = off_q;
    pool_d      = pool_q;
    e_d         = e_q;
    frame_d     = frame_q;
    victim_d    = victim_q;
    oldest_d    = oldest_q;
    slot_d      = slot_q;
    own_t_d     = own_t_q;
    ev_d        = ev_q;
    st_d        = st_q;
    pool_used_d = pool_used_q;
    free_d      = free_q;
    tick_d      = tick_q;
    out_valid_d = out_valid_q;
    out_st_d    = out_st_q;
    out_pa_d    = out_pa_q;
    out_ev_d    = out_ev_q;
    out_evf_d   = out_evf_q;
    out_evs_d   = out_evs_q;
    out_insl_d  = out_insl_q;

    dir_we      = 1'b0;
    dir_waddr   = cnt_q[DirAddrW-1:0];
    dir_wdata   = '0;
    dir_raddr   = {process_id_i, virtual_address_i[31:20]};
    pte_we      = 1'b0;
    pte_waddr   = {pool_q, tbl_q};
    pte_wdata   = '0;
    pte_raddr   = {dir_rdata[PoolW-1:0], tbl_q};
    stamp_we    = 1'b0;
    stamp_waddr = frame_q;
    stamp_raddr = cnt_q[FrameW-1:0];
    own_we      = 1'b0;
    own_raddr   = victim_q;
    disk_we     = 1'b0;
    disk_waddr  = cnt_q[SlotW-1:0];
    disk_wdata  = 1'b1;
    disk_raddr  = cnt_q[SlotW-1:0];

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        dir_we  = 1'b1;
        disk_we = (cnt_q[CntW-1:SlotW] == '0);
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CntW'(Processes * DirSize - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (func_i) begin
            tick_d = tick_q + 1'b1;
          end else begin
            pid_d   = process_id_i;
            dir_d   = virtual_address_i[31:20];
            tbl_d   = virtual_address_i[19:12];
            off_d   = virtual_address_i[11:0];
            ev_d    = 1'b0;
            state_d = S_DIR_RD;
          end
        end
      end
      S_DIR_RD: begin
        if (dir_rdata[DirEntW-1]) begin
          pool_d  = dir_rdata[PoolW-1:0];
          state_d = S_PTE_RD;
        end else if (pool_used_q >= (PoolW+1)'(TablePool)) begin
          st_d    = StNoTable;
          state_d = S_FINISH;
        end else begin
          pool_d      = pool_used_q[PoolW-1:0];
          pool_used_d = pool_used_q + 1'b1;
          dir_we      = 1'b1;
          dir_waddr   = {pid_q, dir_q};
          dir_wdata   = {1'b1, pool_used_q[PoolW-1:0]};
          e_d         = '0;
          cnt_d       = '0;
          state_d     = S_TBL_CLR;
        end
      end
      S_TBL_CLR: begin
        pte_we    = 1'b1;
        pte_waddr = {pool_q, cnt_q[TblW-1:0]};
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q[TblW-1:0] == TblW'(TblSize - 1)) begin
          cnt_d   = '0;
          state_d = S_FREE_SCAN;
        end
      end
      S_PTE_RD: begin
        e_d = pte_rdata;
        if (pte_rdata[PteEntW-1] && !pte_rdata[PteEntW-2]) begin
          frame_d     = (pte_rdata[SlotW-1:0] >= SlotW'(RamFrames)) ? '0
                                                                    : pte_rdata[FrameW-1:0];
          stamp_we    = 1'b1;
          stamp_waddr = frame_d;
          st_d        = StHit;
          state_d     = S_FINISH;
        end else begin
          cnt_d   = '0;
          state_d = S_FREE_SCAN;
        end
      end
      S_FREE_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (free_q[cnt_q[FrameW-1:0]]) begin
          frame_d = cnt_q[FrameW-1:0];
          state_d = S_MAP;
        end else if (cnt_q[FrameW-1:0] == FrameW'(RamFrames - 1)) begin
          cnt_d   = '0;
          state_d = S_OLD_SCAN;
        end
      end
      S_OLD_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q != '0) begin
          if (cnt_q == CntW'(1) || stamp_rdata < oldest_q) begin
            victim_d = prev_idx;
            oldest_d = stamp_rdata;
          end
        end
        if (cnt_q == CntW'(RamFrames)) begin
          cnt_d   = '0;
          state_d = S_DISK_SCAN;
        end
      end
      S_DISK_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q != '0 && disk_rdata[0]) begin
          slot_d     = prev_slot;
          disk_we    = 1'b1;
          disk_waddr = prev_slot;
          disk_wdata = 1'b0;
          state_d    = S_OWN_RD;
        end else if (cnt_q == CntW'(DiskSlots)) begin
          st_d    = StNoDisk;
          state_d = S_FINISH;
        end
      end
      S_OWN_RD: begin
        own_t_d   = own_rdata[TblW-1:0];
        dir_raddr = own_rdata[OwnW-1:TblW];
        state_d   = S_OWNDIR_RD;
      end
      S_OWNDIR_RD: begin
        if (dir_rdata[DirEntW-1]) begin
          pte_we    = 1'b1;
          pte_waddr = {dir_rdata[PoolW-1:0], own_t_q};
          pte_wdata = {2'b11, slot_q};
        end
        ev_d    = 1'b1;
        frame_d = victim_q;
        state_d = S_MAP;
      end
      S_MAP: begin
        pte_we    = 1'b1;
        pte_wdata = {2'b10, (SlotW-FrameW)'(0), frame_q};
        free_d[frame_q] = 1'b0;
        own_we    = 1'b1;
        stamp_we  = 1'b1;
        if (e_q[PteEntW-1]) begin
          disk_we    = 1'b1;
          disk_waddr = e_q[SlotW-1:0];
          disk_wdata = 1'b1;
          st_d       = StSwapped;
        end else begin
          st_d = StMapped;
        end
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_st_d    = st_q;
          out_pa_d    = (st_q == StNoDisk || st_q == StNoTable) ? '0 : {frame_q, off_q};
          out_ev_d    = ev_q;
          out_evf_d   = ev_q ? victim_q : '0;
          out_evs_d   = ev_q ? slot_q : '0;
          out_insl_d  = (st_q == StSwapped) ? e_q[SlotW-1:0] : '0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      pool_used_q <= '0;
      free_q      <= '1;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pool_used_q <= pool_used_d;
      free_q      <= free_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pid_q      <= pid_d;
    dir_q      <= dir_d;
    tbl_q      <= tbl_d;
    off_q      <= off_d;
    pool_q     <= pool_d;
    e_q        <= e_d;
    frame_q    <= frame_d;
    victim_q   <= victim_d;
    oldest_q   <= oldest_d;
    slot_q     <= slot_d;
    own_t_q    <= own_t_d;
    ev_q       <= ev_d;
    st_q       <= st_d;
    out_st_q   <= out_st_d;
    out_pa_q   <= out_pa_d;
    out_ev_q   <= out_ev_d;
    out_evf_q  <= out_evf_d;
    out_evs_q  <= out_evs_d;
    out_insl_q <= out_insl_d;
  end

endmodule

>>> design/tlpw_ram.sv
`timescale 1ns / 1ps
module tlpw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> bench/page_walk_checker.sv
`timescale 1ns / 1ps
module page_walk_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic                        func_i,
  input  logic [tlpw_pkg::PidW-1:0]   process_id_i,
  input  logic [31:0]                 virtual_address_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [tlpw_pkg::StatW-1:0]  status_i,
  input  logic [tlpw_pkg::PaW-1:0]    physical_address_i,
  input  logic                        evicted_i,
  input  logic [tlpw_pkg::FrameW-1:0] evicted_ram_frame_i,
  input  logic [tlpw_pkg::SlotW-1:0]  evicted_disk_slot_i,
  input  logic [tlpw_pkg::SlotW-1:0]  swapped_in_slot_i,
  output int                          errors_o,
  output int                          pending_o
);
  import tlpw_pkg::*;

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [PaW-1:0]    paddr;
    logic              evicted;
    logic [FrameW-1:0] ev_frame;
    logic [SlotW-1:0]  ev_slot;
    logic [SlotW-1:0]  in_slot;
  } xlate_t;

  logic             dir_valid [Processes*DirSize];
  logic [PoolW-1:0] dir_pool  [Processes*DirSize];
  logic             pte_valid [TablePool*TblSize];
  logic             pte_disk  [TablePool*TblSize];
  logic [15:0]      pte_num   [TablePool*TblSize];
  int unsigned      pools_taken;
  logic             frame_busy  [RamFrames];
  logic [31:0]      frame_stamp [RamFrames];
  logic [OwnW-1:0]  frame_owner [RamFrames];
  logic             slot_busy   [DiskSlots];
  logic [31:0]      ticks;

  xlate_t expected_xlates[$];

  initial begin
    for (int i = 0; i < Processes*DirSize; i++) begin
      dir_valid[i] = 1'b0;
      dir_pool[i] = '0;
    end
    for (int i = 0; i < TablePool*TblSize; i++) begin
      pte_valid[i] = 1'b0;
      pte_disk[i] = 1'b0;
      pte_num[i] = '0;
    end
    for (int i = 0; i < RamFrames; i++) begin
      frame_busy[i] = 1'b0;
      frame_stamp[i] = '0;
      frame_owner[i] = '0;
    end
    for (int i = 0; i < DiskSlots; i++) slot_busy[i] = 1'b0;
    pools_taken = 0;
    ticks = '0;
    errors_o = 0;
    pending_o = 0;
  end

  function automatic xlate_t translate(logic [PidW-1:0] pid, logic [31:0] va);
    xlate_t r;
    int unsigned d_idx, p_idx, frame, victim, slot, o_idx;
    logic [DirW-1:0] dir;
    logic [TblW-1:0] tbl;
    logic [OwnW-1:0] own;
    r = '0;
    dir = va[31:20];
    tbl = va[19:12];
    d_idx = pid * DirSize + dir;
    if (!dir_valid[d_idx]) begin
      if (pools_taken >= TablePool) begin
        r.status = StNoTable;
        return r;
      end
      for (int i = 0; i < TblSize; i++) pte_valid[pools_taken*TblSize + i] = 1'b0;
      dir_valid[d_idx] = 1'b1;
      dir_pool[d_idx] = pools_taken[PoolW-1:0];
      pools_taken++;
    end
    p_idx = dir_pool[d_idx] * TblSize + tbl;
    if (pte_valid[p_idx] && !pte_disk[p_idx]) begin
      frame = pte_num[p_idx];
      r.status = StHit;
    end else begin
      frame = RamFrames;
      for (int i = RamFrames - 1; i >= 0; i--) if (!frame_busy[i]) frame = i;
      if (frame == RamFrames) begin
        victim = 0;
        for (int i = 1; i < RamFrames; i++)
          if (frame_stamp[i] < frame_stamp[victim]) victim = i;
        slot = DiskSlots;
        for (int i = DiskSlots - 1; i >= 0; i--) if (!slot_busy[i]) slot = i;
        if (slot == DiskSlots) begin
          r.status = StNoDisk;
          return r;
        end
        slot_busy[slot] = 1'b1;
        own = frame_owner[victim];
        o_idx = dir_pool[own[OwnW-1:TblW] ] * TblSize + own[TblW-1:0];
        pte_valid[o_idx] = 1'b1;
        pte_disk[o_idx] = 1'b1;
        pte_num[o_idx] = 16'(slot);
        frame_busy[victim] = 1'b0;
        r.evicted = 1'b1;
        r.ev_frame = victim[FrameW-1:0];
        r.ev_slot = slot[SlotW-1:0];
        frame = victim;
      end
      if (pte_valid[p_idx]) begin
        r.in_slot = pte_num[p_idx][SlotW-1:0];
        slot_busy[pte_num[p_idx]] = 1'b0;
        r.status = StSwapped;
      end else begin
        r.status = StMapped;
      end
      pte_valid[p_idx] = 1'b1;
      pte_disk[p_idx] = 1'b0;
      pte_num[p_idx] = 16'(frame);
      frame_busy[frame] = 1'b1;
      frame_owner[frame] = {pid, dir, tbl};
    end
    frame_stamp[frame] = ticks;
    r.paddr = {frame[FrameW-1:0], va[11:0]};
    return r;
  endfunction

  always @(posedge clk_i) begin
    xlate_t got, want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        got = '{status_i, physical_address_i, evicted_i, evicted_ram_frame_i,
                evicted_disk_slot_i, swapped_in_slot_i};
        if (expected_xlates.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("unexpected transfer: %p", got);
        end else begin
          want = expected_xlates.pop_front();
          if (got !== want) begin
            errors_o++;
            if (errors_o <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (func_i) ticks++;
        else expected_xlates.push_back(translate(process_id_i, virtual_address_i));
      end
      pending_o = expected_xlates.size();
    end
  end

endmodule

>>> bench/two_level_page_walk_lru_swap_tb.sv
`timescale 1ns / 1ps
module two_level_page_walk_lru_swap_tb;
  import tlpw_pkg::*;

  localparam int IdleLimit = 100000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              func_i = 1'b0;
  logic [PidW-1:0]   process_id_i = '0;
  logic [31:0]       virtual_address_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [StatW-1:0]  status_o;
  logic [PaW-1:0]    physical_address_o;
  logic              evicted_o;
  logic [FrameW-1:0] evicted_ram_frame_o;
  logic [SlotW-1:0]  evicted_disk_slot_o;
  logic [SlotW-1:0]  swapped_in_slot_o;
  int                errors;
  int                pending;
  int                idle_cycles = 0;
  int                stall_mode = 0;
  int                stall_cycle = 0;

  always #2 clk_i = ~clk_i;

  two_level_page_walk_lru_swap DUT (.*);

  page_walk_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .func_i, .process_id_i,
    .virtual_address_i, .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o),
    .physical_address_i(physical_address_o), .evicted_i(evicted_o),
    .evicted_ram_frame_i(evicted_ram_frame_o), .evicted_disk_slot_i(evicted_disk_slot_o),
    .swapped_in_slot_i(swapped_in_slot_o), .errors_o(errors), .pending_o(pending)
  );

  always @(negedge clk_i) begin
    if (stall_cycle == 0) stall_mode <= $urandom_range(0, 2);
    stall_cycle <= (stall_cycle + 1) % 50;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // hold the item until the transfer, then step to the next falling edge
  task automatic send(logic f, logic [PidW-1:0] pid, logic [31:0] va);
    in_valid_i <= 1'b1;
    func_i <= f;
    process_id_i <= pid;
    virtual_address_i <= va;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic send_random();
    logic [DirW-1:0] dir;
    logic [TblW-1:0] tbl;
    dir = ($urandom_range(0, 9) == 0) ? DirW'($urandom) : DirW'($urandom_range(0, 31));
    tbl = ($urandom_range(0, 9) == 0) ? TblW'($urandom) : TblW'($urandom_range(0, 15));
    if ($urandom_range(0, 4) == 0) send(1'b1, PidW'($urandom), $urandom);
    else send(1'b0, PidW'($urandom), {dir, tbl, 12'($urandom)});
  endtask

  initial begin
    int burst;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int d = 0; d < 5; d++) send(1'b0, 2'd0, 32'(d) << 20);
    send(1'b0, 2'd3, 32'hFFFF_FFFF);
    send(1'b0, 2'd0, 32'h0000_0000);
    send(1'b0, 2'd0, 32'h0000_0FFF);
    send(1'b1, 2'd0, 32'h0);
    send(1'b0, 2'd1, 32'h0000_0ABC);
    send(1'b1, 2'd3, 32'hFFFF_FFFF);
    send(1'b0, 2'd2, 32'hAAAA_A555);
    send(1'b0, 2'd2, 32'h5555_5AAA);
    send(1'b0, 2'd3, 32'hFFFF_F000);
    send(1'b0, 2'd1, 32'h0000_1234);
    send(1'b0, 2'd0, 32'h000F_F001);
    pause(1);
    wait (pending == 0);
    @(negedge clk_i);

    for (int n = 0; n < 860; ) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst; b++) send_random();
      n += burst;
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 6));
    end

    for (int k = 0; k < 20; k++) send_random();
    pause(1);

    wait (pending == 0);
    repeat (200) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
